/* hdl/lru_key_table_with_thrash_history_defines.svh */
// Shared assertion macros. Each expects clk and rst_n in scope.
`ifndef LRU_KEY_TABLE_WITH_THRASH_HISTORY_DEFINES_SVH
`define LRU_KEY_TABLE_WITH_THRASH_HISTORY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/lrukt_pkg.sv */
`timescale 1ns / 1ps

package lrukt_pkg;

    localparam int SLOT_W      = 6;
    localparam int OUT_KEY_W   = 32;
    localparam int IN_KEY_W    = 32;
    localparam int STAMP_W     = 32;
    localparam int EVICT_W     = 7;
    localparam int MAX_RESULTS = 64;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_EVICT  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // requests from the table sequencer to the history ring
    typedef struct packed {
        logic scan;
        logic push;
        logic clear;
    } hist_ctrl_t;

    // scan status from the history ring
    typedef struct packed {
        logic done;
        logic found;
    } hist_stat_t;

endpackage

/* hdl/lrukt_history.sv */
`timescale 1ns / 1ps
`include "lru_key_table_with_thrash_history_defines.svh"

module lrukt_history #(
    parameter int HISTORY_DEPTH = 256,
    parameter int KW            = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrukt_pkg::hist_ctrl_t ctrl,
    input  logic [KW-1:0]         key,
    output lrukt_pkg::hist_stat_t stat
);

    localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);

    logic [KW-1:0]  hist_mem [0:HISTORY_DEPTH-1];
    logic [KW-1:0]  rd_reg;

    logic [HIW-1:0] head_reg, head_next;
    logic [HCW-1:0] count_reg, count_next;
    logic [HIW-1:0] pos_reg, pos_next;
    logic [HCW-1:0] rem_reg, rem_next;
    logic           pend_reg, pend_next;
    logic           busy_reg, busy_next;

    logic           rd_en;
    logic           wr_en;
    logic [HIW-1:0] wr_addr;
    logic [HCW:0]   tail_sum;
    logic [HCW:0]   tail_wrap;
    logic           match;
    logic           done;

    assign match = pend_reg && (rd_reg == key);
    assign done  = busy_reg && (match || ((rem_reg == '0) && !pend_reg));
    assign stat.done  = done;
    assign stat.found = match;

    // head + count stays below twice the depth, so one subtract wraps it
    assign tail_sum  = (HCW+1)'(head_reg) + (HCW+1)'(count_reg);
    assign tail_wrap = (tail_sum >= (HCW+1)'(HISTORY_DEPTH))
                       ? tail_sum - (HCW+1)'(HISTORY_DEPTH) : tail_sum;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        pend_next  = pend_reg;
        busy_next  = busy_reg;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = HIW'(tail_wrap);

        if (ctrl.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (ctrl.push)
        begin
            wr_en = 1'b1;
            if (count_reg == HCW'(HISTORY_DEPTH))
            begin
                // ring full: overwrite the oldest key
                wr_addr   = head_reg;
                head_next = (head_reg == HIW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + HIW'(1);
            end
            else
            begin
                count_next = count_reg + HCW'(1);
            end
        end

        if (ctrl.scan)
        begin
            busy_next = 1'b1;
            pos_next  = head_reg;
            rem_next  = count_reg;
            pend_next = 1'b0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
            pend_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_reg != '0)
            begin
                rd_en     = 1'b1;
                pos_next  = (pos_reg == HIW'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + HIW'(1);
                rem_next  = rem_reg - HCW'(1);
                pend_next = 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= key;
        end
        if (rd_en)
        begin
            rd_reg <= hist_mem[pos_reg];
        end
    end

    `CHK_NOW(a_hist_count_max, 1'b1, count_reg <= HCW'(HISTORY_DEPTH), "history count overflow")
    `CHK_NOW(a_no_push_in_scan, busy_reg, !ctrl.push, "history push during scan")
    `CHK_NEXT(a_scan_busy, ctrl.scan, busy_reg, "history scan did not start")

endmodule

/* hdl/lru_key_table_with_thrash_history.sv */
`timescale 1ns / 1ps
// LRU key table with eviction history.
// Input channel (in_valid/in_stall) carries op, key, evict_count; a transaction
// is taken when in_valid is high and in_stall low. in_stall is high while an
// operation is in progress, so one operation is handled at a time.
// Output channel (out_valid/out_stall) carries one result per transaction;
// last marks the final result of an operation. Evict gives one result per
// removed entry (at most 64), one empty result if none; other ops give exactly one.
// Steps with N stored entries and H history keys:
//   lookup: one key-memory read per cycle until a match or all N are read,
//   insert: one history-ring read per cycle over up to H keys, then the write,
//   evict:  per victim a stamp scan, a read of the last entry and a write,
//   clear:  empties the history ring, then gives an empty result.
// The single read port of the key/stamp memories and of the history ring sets
// these read rates. A stalled result stays in the output register; the sequencer
// waits before loading the next one. Reset empties the table and the history
// and zeroes the use counter; memory contents need no clearing.
`include "lru_key_table_with_thrash_history_defines.svh"

module lru_key_table_with_thrash_history #(
    parameter int ENTRIES       = 64,
    parameter int HISTORY_DEPTH = 256,
    parameter int KEY_BITS      = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [lrukt_pkg::IN_KEY_W-1:0]      key,
    input  logic [lrukt_pkg::EVICT_W-1:0]       evict_count,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic [lrukt_pkg::SLOT_W-1:0]        slot_index,
    output logic                                thrash,
    output logic                                table_full,
    output logic                                evicted_valid,
    output logic [lrukt_pkg::OUT_KEY_W-1:0]     evicted_key,
    output logic                                last
);

    localparam int KW  = (KEY_BITS < lrukt_pkg::IN_KEY_W) ? KEY_BITS : lrukt_pkg::IN_KEY_W;
    localparam int EIW = $clog2(ENTRIES);
    localparam int ECW = $clog2(ENTRIES + 1);
    localparam int SW  = lrukt_pkg::STAMP_W;
    localparam int EW  = lrukt_pkg::EVICT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK,
        S_LK_HIT,
        S_INS_HIST,
        S_INS_WR,
        S_EV_SCAN,
        S_EV_RDL,
        S_EV_WR
    } state_t;
    // S_DONE emits a result with only last set
    localparam state_t S_DONE_ALIAS = S_IDLE;

    state_t         state_reg, state_next;
    logic           done_reg, done_next;
    logic [KW-1:0]  key_reg, key_next;
    logic [EW-1:0]  want_reg, want_next;
    logic [ECW-1:0] count_reg, count_next;
    logic [SW-1:0]  use_cnt_reg, use_cnt_next;
    logic [ECW-1:0] scan_idx_reg, scan_idx_next;
    logic [EIW-1:0] cmp_idx_reg, cmp_idx_next;
    logic           pend_reg, pend_next;
    logic [EIW-1:0] best_idx_reg, best_idx_next;
    logic [SW-1:0]  best_stamp_reg, best_stamp_next;
    logic [KW-1:0]  best_key_reg, best_key_next;
    logic           thr_reg, thr_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            hit_reg, hit_next;
    logic [lrukt_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic                            thrash_reg, thrash_next;
    logic                            full_reg, full_next;
    logic                            ev_valid_reg, ev_valid_next;
    logic [lrukt_pkg::OUT_KEY_W-1:0] ev_key_reg, ev_key_next;
    logic                            last_reg, last_next;

    // result to load into the output register
    logic                            ld;
    logic                            ld_hit;
    logic [EIW-1:0]                  ld_slot;
    logic                            ld_thrash;
    logic                            ld_full;
    logic                            ld_ev;
    logic                            ld_last;

    logic [KW-1:0]  key_mem   [0:ENTRIES-1];
    logic [SW-1:0]  stamp_mem [0:ENTRIES-1];
    logic [KW-1:0]  key_rd_reg;
    logic [SW-1:0]  stamp_rd_reg;
    logic           key_we, key_re, stamp_we, stamp_re;
    logic [EIW-1:0] key_wa, key_ra, stamp_wa, stamp_ra;
    logic [KW-1:0]  key_wd;
    logic [SW-1:0]  stamp_wd;

    logic           out_free;
    logic [EW-1:0]  want_cap;
    logic [ECW-1:0] count_m1;
    logic [EIW-1:0] last_idx;
    logic           ev_last;

    lrukt_pkg::hist_ctrl_t hctrl;
    lrukt_pkg::hist_stat_t hstat;
    logic [KW-1:0]         hist_key;

    lrukt_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .KW            (KW)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (hctrl),
        .key   (hist_key),
        .stat  (hstat)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign want_cap = (evict_count > EW'(lrukt_pkg::MAX_RESULTS))
                      ? EW'(lrukt_pkg::MAX_RESULTS) : evict_count;
    assign count_m1 = count_reg - ECW'(1);
    assign last_idx = count_m1[EIW-1:0];
    assign ev_last  = (want_reg == EW'(1)) || (count_reg == ECW'(1));
    assign in_stall = (state_reg != S_IDLE) || done_reg;

    always_comb
    begin
        state_next      = state_reg;
        done_next       = done_reg;
        key_next        = key_reg;
        want_next       = want_reg;
        count_next      = count_reg;
        use_cnt_next    = use_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        pend_next       = pend_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        best_key_next   = best_key_reg;
        thr_next        = thr_reg;

        key_we   = 1'b0;
        key_wa   = best_idx_reg;
        key_wd   = key_rd_reg;
        key_re   = 1'b0;
        key_ra   = scan_idx_reg[EIW-1:0];
        stamp_we = 1'b0;
        stamp_wa = best_idx_reg;
        stamp_wd = stamp_rd_reg;
        stamp_re = 1'b0;
        stamp_ra = scan_idx_reg[EIW-1:0];

        hctrl    = '0;
        hist_key = key_reg;

        ld        = 1'b0;
        ld_hit    = 1'b0;
        ld_slot   = '0;
        ld_thrash = 1'b0;
        ld_full   = 1'b0;
        ld_ev     = 1'b0;
        ld_last   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    // empty result: miss, clear, or nothing to evict
                    if (out_free)
                    begin
                        ld        = 1'b1;
                        ld_last   = 1'b1;
                        done_next = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    key_next      = key[KW-1:0];
                    want_next     = want_cap;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    case (lrukt_pkg::op_t'(op))
                        lrukt_pkg::OP_LOOKUP:
                        begin
                            state_next = S_LK;
                        end
                        lrukt_pkg::OP_INSERT:
                        begin
                            hctrl.scan = 1'b1;
                            state_next = S_INS_HIST;
                        end
                        lrukt_pkg::OP_EVICT:
                        begin
                            if ((want_cap == '0) || (count_reg == '0))
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EV_SCAN;
                            end
                        end
                        default:
                        begin
                            hctrl.clear = 1'b1;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            S_LK:
            begin
                if (pend_reg && (key_rd_reg == key_reg))
                begin
                    best_idx_next = cmp_idx_reg;
                    pend_next     = 1'b0;
                    state_next    = S_LK_HIT;
                end
                else if (scan_idx_reg < count_reg)
                begin
                    key_re        = 1'b1;
                    cmp_idx_next  = scan_idx_reg[EIW-1:0];
                    scan_idx_next = scan_idx_reg + ECW'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    done_next  = 1'b1;
                    state_next = S_DONE_ALIAS;
                end
            end

            S_LK_HIT:
            begin
                if (out_free)
                begin
                    stamp_we     = 1'b1;
                    stamp_wd     = use_cnt_reg + SW'(1);
                    use_cnt_next = use_cnt_reg + SW'(1);
                    ld           = 1'b1;
                    ld_hit       = 1'b1;
                    ld_slot      = best_idx_reg;
                    ld_last      = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_INS_HIST:
            begin
                if (hstat.done)
                begin
                    thr_next   = hstat.found;
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                if (out_free)
                begin
                    ld        = 1'b1;
                    ld_thrash = thr_reg;
                    ld_last   = 1'b1;
                    if (count_reg >= ECW'(ENTRIES))
                    begin
                        ld_full = 1'b1;
                    end
                    else
                    begin
                        key_we       = 1'b1;
                        key_wa       = count_reg[EIW-1:0];
                        key_wd       = key_reg;
                        stamp_we     = 1'b1;
                        stamp_wa     = count_reg[EIW-1:0];
                        stamp_wd     = use_cnt_reg + SW'(1);
                        use_cnt_next = use_cnt_reg + SW'(1);
                        count_next   = count_reg + ECW'(1);
                        ld_slot      = count_reg[EIW-1:0];
                    end
                    state_next = S_IDLE;
                end
            end

            S_EV_SCAN:
            begin
                // strict less-than keeps the lowest slot on ties
                if (pend_reg && ((cmp_idx_reg == '0) || (stamp_rd_reg < best_stamp_reg)))
                begin
                    best_idx_next   = cmp_idx_reg;
                    best_stamp_next = stamp_rd_reg;
                    best_key_next   = key_rd_reg;
                end
                if (scan_idx_reg < count_reg)
                begin
                    key_re        = 1'b1;
                    stamp_re      = 1'b1;
                    cmp_idx_next  = scan_idx_reg[EIW-1:0];
                    scan_idx_next = scan_idx_reg + ECW'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_EV_RDL;
                end
            end

            S_EV_RDL:
            begin
                key_re     = 1'b1;
                key_ra     = last_idx;
                stamp_re   = 1'b1;
                stamp_ra   = last_idx;
                state_next = S_EV_WR;
            end

            S_EV_WR:
            begin
                if (out_free)
                begin
                    // move the last entry into the victim's slot
                    key_we        = 1'b1;
                    stamp_we      = 1'b1;
                    hctrl.push    = 1'b1;
                    hist_key      = best_key_reg;
                    count_next    = count_m1;
                    want_next     = want_reg - EW'(1);
                    ld            = 1'b1;
                    ld_ev         = 1'b1;
                    ld_last       = ev_last;
                    scan_idx_next = '0;
                    pend_next     = 1'b0;
                    state_next    = ev_last ? S_IDLE : S_EV_SCAN;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        thrash_next    = thrash_reg;
        full_next      = full_reg;
        ev_valid_next  = ev_valid_reg;
        ev_key_next    = ev_key_reg;
        last_next      = last_reg;
        if (ld)
        begin
            out_valid_next = 1'b1;
            hit_next       = ld_hit;
            slot_next      = lrukt_pkg::SLOT_W'(ld_slot);
            thrash_next    = ld_thrash;
            full_next      = ld_full;
            ev_valid_next  = ld_ev;
            ev_key_next    = ld_ev ? lrukt_pkg::OUT_KEY_W'(best_key_reg) : '0;
            last_next      = ld_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            count_reg     <= '0;
            use_cnt_reg   <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            use_cnt_reg   <= use_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        want_reg       <= want_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        best_key_reg   <= best_key_next;
        thr_reg        <= thr_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        thrash_reg     <= thrash_next;
        full_reg       <= full_next;
        ev_valid_reg   <= ev_valid_next;
        ev_key_reg     <= ev_key_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (key_re)
        begin
            key_rd_reg <= key_mem[key_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_wa] <= stamp_wd;
        end
        if (stamp_re)
        begin
            stamp_rd_reg <= stamp_mem[stamp_ra];
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot_index    = slot_reg;
    assign thrash        = thrash_reg;
    assign table_full    = full_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_key   = ev_key_reg;
    assign last          = last_reg;

    `CHK_NOW(a_count_max, 1'b1, count_reg <= ECW'(ENTRIES), "entry count above table size")
    `CHK_NOW(a_evict_nonempty, ld && ld_ev, count_reg != '0, "eviction from empty table")
    `CHK_NEXT(a_last_to_idle, ld && ld_last, (state_reg == S_IDLE) && !done_reg, "not idle after last result")

endmodule
